[rtl/packet_latency_match_table_top_assert.svh]
// Assertion macros for the packet latency match table.
`ifndef PACKET_LATENCY_MATCH_TABLE_TOP_ASSERT_SVH
`define PACKET_LATENCY_MATCH_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PLMT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PLMT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PLMT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLMT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/plmt_pkg.sv]
// Types, codes and helpers shared by the packet latency match table.
`timescale 1ns / 1ps
package plmt_pkg;

  typedef enum logic [1:0] {
    FN_RX       = 2'd0,
    FN_WL_TX    = 2'd1,
    FN_WIRED_TX = 2'd2,
    FN_WL_ACK   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STS_RECORDED   = 3'd0,
    STS_FULL       = 3'd1,
    STS_NOT_TCP    = 3'd2,
    STS_DISPATCHED = 3'd3,
    STS_COMPLETED  = 3'd4,
    STS_IGNORED    = 3'd5,
    STS_NOT_FOUND  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_ACT,
    S_MOVE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [63:0] tag;
    logic [31:0] src;
    logic [31:0] dst;
    logic [63:0] arrival;
    logic [63:0] dispatch;
  } entry_t;

  localparam logic [7:0]  PRIV_NET_10  = 8'h0a;
  localparam logic [11:0] PRIV_NET_172 = 12'hac1;
  localparam logic [15:0] PRIV_NET_192 = 16'hc0a8;

  // 10/8, 172.16/12, 192.168/16 on octets, first octet in the top byte
  function automatic logic addr_private(input logic [31:0] a);
    return (a[31:24] == PRIV_NET_10) || (a[31:20] == PRIV_NET_172) ||
           (a[31:16] == PRIV_NET_192);
  endfunction

endpackage

[rtl/plmt_in_if.sv]
// Input event channel of the packet latency match table.
`timescale 1ns / 1ps
interface plmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] packet_tag;
  logic        is_tcp;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [63:0] now_ns;

  modport source (output valid, func, packet_tag, is_tcp, src_addr, dst_addr, now_ns,
                  input ready);
  modport sink (input valid, func, packet_tag, is_tcp, src_addr, dst_addr, now_ns,
                output ready);
endinterface

[rtl/plmt_out_if.sv]
// Result channel of the packet latency match table.
`timescale 1ns / 1ps
interface plmt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] rec_src_addr;
  logic [31:0] rec_dst_addr;
  logic [63:0] arrival_ns;
  logic [63:0] dispatch_ns;
  logic [63:0] sent_ns;
  logic [7:0]  occupancy;

  modport source (output valid, status, rec_src_addr, rec_dst_addr, arrival_ns,
                  dispatch_ns, sent_ns, occupancy, input ready);
  modport sink (input valid, status, rec_src_addr, rec_dst_addr, arrival_ns,
                dispatch_ns, sent_ns, occupancy, output ready);
endinterface

[rtl/packet_latency_match_table_top.sv]
// Packet latency match table: tag-keyed in-flight table with sequential search.
// Receives, and any event on an empty table, go from DECIDE straight to RESULT.
// A search reads one row per cycle: a hit goes on to ACT, and through MOVE when the entry
// completes and the last entry moves into its slot; a miss ends at the last live row.
// One event at a time: the next beat is taken only after the result loads into the output register.
// Synchronous active-low reset clears the occupancy and handshake state only.
`timescale 1ns / 1ps
`include "packet_latency_match_table_top_assert.svh"
module packet_latency_match_table_top #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  plmt_in_if.sink    in_chan,
  plmt_out_if.source out_chan
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  plmt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]    hit_idx_r, hit_idx_nxt;
  plmt_pkg::entry_t hit_row_r, hit_row_nxt;
  plmt_pkg::status_t status_r, status_nxt;

  // latched event
  logic [1:0]  func_r;
  logic [63:0] tag_r;
  logic        tcp_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [63:0] now_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [31:0] o_src_r, o_src_nxt;
  logic [31:0] o_dst_r, o_dst_nxt;
  logic [63:0] o_rcv_r, o_rcv_nxt;
  logic [63:0] o_dsp_r, o_dsp_nxt;
  logic [63:0] o_sent_r, o_sent_nxt;
  logic [7:0]  o_occ_r, o_occ_nxt;

  // table memory
  plmt_pkg::entry_t mem [TABLE_DEPTH];
  plmt_pkg::entry_t rd_data_r;
  plmt_pkg::entry_t mem_wd;
  logic [IW-1:0]    mem_wa, mem_ra;
  logic             mem_we;

  logic          in_acc;
  logic          out_free;
  logic          hit_priv;
  logic          tag_hit;
  logic [CW-1:0] cmp_idx_ext;
  logic [CW-1:0] last_cnt;
  plmt_pkg::func_t fn;

  assign in_acc      = in_chan.valid && in_chan.ready;
  assign out_free    = !out_valid_r || out_chan.ready;
  assign hit_priv    = plmt_pkg::addr_private(hit_row_r.src);
  assign tag_hit     = (rd_data_r.tag == tag_r);
  assign cmp_idx_ext = CW'(cmp_idx_r);
  assign last_cnt    = count_r - CW'(1);
  assign fn          = plmt_pkg::func_t'(func_r);

  assign in_chan.ready         = (state_r == plmt_pkg::S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = o_status_r;
  assign out_chan.rec_src_addr = o_src_r;
  assign out_chan.rec_dst_addr = o_dst_r;
  assign out_chan.arrival_ns   = o_rcv_r;
  assign out_chan.dispatch_ns  = o_dsp_r;
  assign out_chan.sent_ns      = o_sent_r;
  assign out_chan.occupancy    = o_occ_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plmt_pkg::S_IDLE: begin
        if (in_acc) state_nxt = plmt_pkg::S_DECIDE;
      end
      plmt_pkg::S_DECIDE: begin
        if (fn == plmt_pkg::FN_RX || count_r == '0) state_nxt = plmt_pkg::S_RESULT;
        else state_nxt = plmt_pkg::S_SEARCH;
      end
      plmt_pkg::S_SEARCH: begin
        if (tag_hit) state_nxt = plmt_pkg::S_ACT;
        else if (cmp_idx_ext + CW'(1) == count_r) state_nxt = plmt_pkg::S_RESULT;
      end
      plmt_pkg::S_ACT: begin
        if ((fn == plmt_pkg::FN_WIRED_TX && hit_priv) ||
            (fn == plmt_pkg::FN_WL_ACK && !hit_priv)) state_nxt = plmt_pkg::S_MOVE;
        else state_nxt = plmt_pkg::S_RESULT;
      end
      plmt_pkg::S_MOVE: state_nxt = plmt_pkg::S_RESULT;
      plmt_pkg::S_RESULT: begin
        if (out_free) state_nxt = plmt_pkg::S_IDLE;
      end
      default: state_nxt = plmt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt     = count_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_idx_nxt   = hit_idx_r;
    hit_row_nxt   = hit_row_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    o_status_nxt  = o_status_r;
    o_src_nxt     = o_src_r;
    o_dst_nxt     = o_dst_r;
    o_rcv_nxt     = o_rcv_r;
    o_dsp_nxt     = o_dsp_r;
    o_sent_nxt    = o_sent_r;
    o_occ_nxt     = o_occ_r;
    mem_we        = 1'b0;
    mem_wa        = hit_idx_r;
    mem_wd        = hit_row_r;
    mem_ra        = cmp_idx_r + IW'(1);
    unique case (state_r)
      plmt_pkg::S_IDLE: ;
      plmt_pkg::S_DECIDE: begin
        mem_ra      = '0;
        cmp_idx_nxt = '0;
        if (fn == plmt_pkg::FN_RX) begin
          if (count_r >= CW'(TABLE_DEPTH)) begin
            status_nxt = plmt_pkg::STS_FULL;
          end else if (!tcp_r) begin
            status_nxt = plmt_pkg::STS_NOT_TCP;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = count_r[IW-1:0];
            mem_wd     = '{tag: tag_r, src: src_r, dst: dst_r, arrival: now_r,
                           dispatch: 64'd0};
            count_nxt  = count_r + CW'(1);
            status_nxt = plmt_pkg::STS_RECORDED;
          end
        end else if (count_r == '0) begin
          status_nxt = plmt_pkg::STS_NOT_FOUND;
        end
      end
      plmt_pkg::S_SEARCH: begin
        // rd_data_r holds row cmp_idx_r; fetch the next row meanwhile
        if (tag_hit) begin
          hit_row_nxt = rd_data_r;
          hit_idx_nxt = cmp_idx_r;
        end else if (cmp_idx_ext + CW'(1) == count_r) begin
          status_nxt = plmt_pkg::STS_NOT_FOUND;
        end else begin
          cmp_idx_nxt = cmp_idx_r + IW'(1);
        end
      end
      plmt_pkg::S_ACT: begin
        mem_ra = last_cnt[IW-1:0];
        if (fn == plmt_pkg::FN_WL_TX) begin
          if (!hit_priv) begin
            mem_we          = 1'b1;
            mem_wd          = hit_row_r;
            mem_wd.dispatch = now_r;
            status_nxt      = plmt_pkg::STS_DISPATCHED;
          end else begin
            status_nxt = plmt_pkg::STS_IGNORED;
          end
        end else if ((fn == plmt_pkg::FN_WIRED_TX && hit_priv) ||
                     (fn == plmt_pkg::FN_WL_ACK && !hit_priv)) begin
          status_nxt = plmt_pkg::STS_COMPLETED;
        end else begin
          status_nxt = plmt_pkg::STS_IGNORED;
        end
      end
      plmt_pkg::S_MOVE: begin
        // copy the last live row into the freed slot
        mem_we    = 1'b1;
        mem_wd    = rd_data_r;
        count_nxt = last_cnt;
      end
      plmt_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_occ_nxt     = 8'(count_r);
          if (status_r == plmt_pkg::STS_COMPLETED) begin
            o_src_nxt  = hit_row_r.src;
            o_dst_nxt  = hit_row_r.dst;
            o_rcv_nxt  = hit_row_r.arrival;
            o_dsp_nxt  = hit_row_r.dispatch;
            o_sent_nxt = now_r;
          end else begin
            o_src_nxt  = '0;
            o_dst_nxt  = '0;
            o_rcv_nxt  = '0;
            o_dsp_nxt  = '0;
            o_sent_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plmt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_row_r  <= hit_row_nxt;
    status_r   <= status_nxt;
    o_status_r <= o_status_nxt;
    o_src_r    <= o_src_nxt;
    o_dst_r    <= o_dst_nxt;
    o_rcv_r    <= o_rcv_nxt;
    o_dsp_r    <= o_dsp_nxt;
    o_sent_r   <= o_sent_nxt;
    o_occ_r    <= o_occ_nxt;
    if (in_acc) begin
      func_r <= in_chan.func;
      tag_r  <= in_chan.packet_tag;
      tcp_r  <= in_chan.is_tcp;
      src_r  <= in_chan.src_addr;
      dst_r  <= in_chan.dst_addr;
      now_r  <= in_chan.now_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  `PLMT_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(TABLE_DEPTH))
  `PLMT_ASSERT_NXT(a_accept_decide, clk, rst_n, in_acc, state_r == plmt_pkg::S_DECIDE)
  `PLMT_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_r == plmt_pkg::S_SEARCH, cmp_idx_ext < count_r)
  `PLMT_ASSERT_NXT(a_move_shrinks, clk, rst_n, state_r == plmt_pkg::S_MOVE, count_r == $past(count_r) - CW'(1))

endmodule
